>>> rtl/polynomial_multiplier_unit_defines.svh
// ----------------------------------------------------------------------------
// Polynomial multiplier assertion macros
// Shared check macros for the polynomial multiplier; clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef POLYNOMIAL_MULTIPLIER_UNIT_DEFINES_SVH
`define POLYNOMIAL_MULTIPLIER_UNIT_DEFINES_SVH

// property must hold at every edge outside reset
`define PMU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define PMU_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> rtl/pmu_pkg.sv
// ----------------------------------------------------------------------------
// Polynomial multiplier package
// Field widths, item codes and shared types.
// ----------------------------------------------------------------------------
package pmu_pkg;

	localparam int MAX_TERMS_DEF = 1024;

	localparam int FUNC_W = 2;
	localparam int COEF_W = 8;
	localparam int MUL_W  = 2 * COEF_W;
	localparam int PROD_W = 26;
	localparam int DEG_W  = 11;

	localparam logic [FUNC_W-1:0] FUNC_LOAD_A  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOAD_B  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd3;

	// controls into the multiply-accumulate unit
	typedef struct packed {
		logic clear;
		logic valid;
	} mac_ctl_t;

endpackage

>>> rtl/pmu_ram.sv
// ----------------------------------------------------------------------------
// Coefficient store
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pmu_ram #(
	parameter int DEPTH = pmu_pkg::MAX_TERMS_DEF,
	parameter int AW    = 10
) (
	input  logic                               clk,
	input  logic                               we,
	input  logic [AW-1:0]                      waddr,
	input  logic signed [pmu_pkg::COEF_W-1:0]  wdata,
	input  logic                               re,
	input  logic [AW-1:0]                      raddr,
	output logic signed [pmu_pkg::COEF_W-1:0]  rdata
);
	import pmu_pkg::*;

	logic [COEF_W-1:0] mem [DEPTH];
	logic [COEF_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = $signed(rdata_q);

endmodule

>>> rtl/pmu_mac.sv
// ----------------------------------------------------------------------------
// Multiply-accumulate unit
// Registered 8x8 product, then a modular 26-bit running sum.
// ----------------------------------------------------------------------------
module pmu_mac (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pmu_pkg::mac_ctl_t                  ctl,
	input  logic signed [pmu_pkg::COEF_W-1:0]  a,
	input  logic signed [pmu_pkg::COEF_W-1:0]  b,
	output logic signed [pmu_pkg::PROD_W-1:0]  acc,
	output logic                               busy
);
	import pmu_pkg::*;

	logic                     v_s2;
	logic signed [MUL_W-1:0]  prod_s2;
	logic signed [PROD_W-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= a * b;
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (v_s2) begin
			// sum wraps at 26 bits, same as the result field
			acc_q <= acc_q + PROD_W'(prod_s2);
		end
	end

	assign acc  = acc_q;
	assign busy = v_s2;

endmodule

>>> rtl/polynomial_multiplier_unit.sv
// ----------------------------------------------------------------------------
// Polynomial multiplier unit
// Exact integer product of two loaded polynomials, read out term by term.
// ----------------------------------------------------------------------------
// Load items (func load A / load B) append a signed 8-bit coefficient to A or
// B, highest degree first; loads beyond MAX_TERMS are dropped. A restart item
// empties both polynomials and rewinds the read sequence (store contents are
// kept but no longer visible). Each read item returns one result item: the
// next product coefficient, highest degree first, with its degree, a last
// flag on the constant term and in_range set. A read with an empty polynomial
// or after the constant term has gone returns in_range low and zero fields.
// Loads and restarts leave the unit ready for the next request. A read walks
// setup and bounds, then one multiply-accumulate per cycle for each of the n
// A/B term pairs that meet at that degree (1 .. MAX_TERMS), fed by one read
// port on each store, then pipeline drain and the result hand-off. The stores
// need no clearing pass: only entries already loaded are ever read.
// ----------------------------------------------------------------------------
`include "polynomial_multiplier_unit_defines.svh"

module polynomial_multiplier_unit #(
	parameter int MAX_TERMS = pmu_pkg::MAX_TERMS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_ready,
	input  logic [pmu_pkg::FUNC_W-1:0]         func,
	input  logic signed [pmu_pkg::COEF_W-1:0]  coefficient,
	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	output logic signed [pmu_pkg::PROD_W-1:0]  product_coefficient,
	output logic [pmu_pkg::DEG_W-1:0]          degree,
	output logic                               last,
	output logic                               in_range
);
	import pmu_pkg::*;

	// store address, fill count, read position / degree, sum widths
	localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int CW = $clog2(MAX_TERMS + 1);
	localparam int PW = $clog2(2 * MAX_TERMS);
	localparam int SW = PW + 1;

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SETUP  = 3'd1;
	localparam logic [2:0] ST_BOUNDS = 3'd2;
	localparam logic [2:0] ST_RUN    = 3'd3;
	localparam logic [2:0] ST_DRAIN  = 3'd4;
	localparam logic [2:0] ST_EMIT   = 3'd5;

	logic [2:0]    state_q;
	logic [CW-1:0] count_a_q;
	logic [CW-1:0] count_b_q;
	logic [PW-1:0] rpos_q;
	logic [PW-1:0] d_q;      // degree being computed
	logic [PW-1:0] da_q;     // degree of the current A term
	logic [PW-1:0] hi_q;     // highest A degree that meets B at d_q
	logic          inr_q;
	logic          rd_v_s1;  // store read data valid

	logic                     out_valid_q;
	logic signed [PROD_W-1:0] out_pc_q;
	logic [DEG_W-1:0]         out_deg_q;
	logic                     out_last_q;
	logic                     out_inr_q;

	logic                     accept;
	logic                     we_a;
	logic                     we_b;
	logic                     issue;
	logic [SW-1:0]            total;
	logic [SW-1:0]            rpos_ext;
	logic                     no_term;
	logic [SW-1:0]            cam1;
	logic [SW-1:0]            cbm1;
	logic [SW-1:0]            dx;
	logic [SW-1:0]            lo;
	logic [SW-1:0]            hi;
	logic [SW-1:0]            raddr_a;
	logic [SW-1:0]            raddr_b;
	logic signed [COEF_W-1:0] rdata_a;
	logic signed [COEF_W-1:0] rdata_b;
	logic signed [PROD_W-1:0] acc;
	logic                     mac_busy;
	logic                     out_free;
	mac_ctl_t                 mac_ctl;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;

	// a full store silently drops further loads
	assign we_a = accept && (func == FUNC_LOAD_A) && (count_a_q != CW'(MAX_TERMS));
	assign we_b = accept && (func == FUNC_LOAD_B) && (count_b_q != CW'(MAX_TERMS));

	// top degree of the product and whether this read has a term at all
	assign total    = SW'(count_a_q) + SW'(count_b_q) - SW'(2);
	assign rpos_ext = SW'(rpos_q);
	assign no_term  = (count_a_q == '0) || (count_b_q == '0) || (rpos_ext > total);

	// A degrees that pair with a B term at degree d: max(0, d-(cb-1)) .. min(ca-1, d)
	assign cam1 = SW'(count_a_q) - SW'(1);
	assign cbm1 = SW'(count_b_q) - SW'(1);
	assign dx   = SW'(d_q);
	assign lo   = (dx >= cbm1) ? (dx - cbm1) : '0;
	assign hi   = (dx < cam1) ? dx : cam1;

	// A index ca-1-da, B index cb-1-(d-da)
	assign issue   = (state_q == ST_RUN);
	assign raddr_a = cam1 - SW'(da_q);
	assign raddr_b = cbm1 - dx + SW'(da_q);

	assign out_free = !out_valid_q || rsp_ready;

	assign mac_ctl.clear = (state_q == ST_BOUNDS);
	assign mac_ctl.valid = rd_v_s1;

	pmu_ram #(
		.DEPTH (MAX_TERMS),
		.AW    (AW)
	) u_store_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (count_a_q[AW-1:0]),
		.wdata (coefficient),
		.re    (issue),
		.raddr (raddr_a[AW-1:0]),
		.rdata (rdata_a)
	);

	pmu_ram #(
		.DEPTH (MAX_TERMS),
		.AW    (AW)
	) u_store_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (count_b_q[AW-1:0]),
		.wdata (coefficient),
		.re    (issue),
		.raddr (raddr_b[AW-1:0]),
		.rdata (rdata_b)
	);

	pmu_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a      (rdata_a),
		.b      (rdata_b),
		.acc    (acc),
		.busy   (mac_busy)
	);

	// sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_a_q <= '0;
			count_b_q <= '0;
			rpos_q    <= '0;
			inr_q     <= 1'b0;
			rd_v_s1   <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (func)
							FUNC_LOAD_A: begin
								if (we_a) begin
									count_a_q <= count_a_q + CW'(1);
								end
							end
							FUNC_LOAD_B: begin
								if (we_b) begin
									count_b_q <= count_b_q + CW'(1);
								end
							end
							FUNC_READ: begin
								state_q <= ST_SETUP;
							end
							FUNC_RESTART: begin
								count_a_q <= '0;
								count_b_q <= '0;
								rpos_q    <= '0;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_SETUP: begin
					inr_q <= !no_term;
					if (no_term) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_BOUNDS;
					end
				end
				ST_BOUNDS: begin
					rpos_q  <= rpos_q + PW'(1);
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (da_q == hi_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!rd_v_s1 && !mac_busy) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// term walk registers
	always_ff @(posedge clk) begin
		if (state_q == ST_SETUP) begin
			d_q <= PW'(total - rpos_ext);
		end
		if (state_q == ST_BOUNDS) begin
			da_q <= PW'(lo);
			hi_q <= PW'(hi);
		end else if (issue) begin
			da_q <= da_q + PW'(1);
		end
	end

	// output register: a finished item waits here while the sequencer goes idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_EMIT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && out_free) begin
			out_pc_q   <= inr_q ? acc : '0;
			out_deg_q  <= inr_q ? DEG_W'(d_q) : '0;
			out_last_q <= inr_q && (d_q == '0);
			out_inr_q  <= inr_q;
		end
	end

	assign rsp_valid           = out_valid_q;
	assign product_coefficient = out_pc_q;
	assign degree              = out_deg_q;
	assign last                = out_last_q;
	assign in_range            = out_inr_q;

	// checks
	`PMU_ASSERT(a_restart_clears, accept && (func == FUNC_RESTART) |=> (count_a_q == '0) && (count_b_q == '0) && (rpos_q == '0), "restart did not clear the counters")
	`PMU_ASSERT(a_idle_mac_empty, (state_q == ST_IDLE) |-> (!rd_v_s1 && !mac_busy), "MAC pipeline busy while idle")
	`PMU_ASSERT_NEVER(a_last_needs_range, out_valid_q && out_last_q && !out_inr_q, "last flagged on an out-of-range item")
	`PMU_ASSERT_NEVER(a_count_bound, (count_a_q > CW'(MAX_TERMS)) || (count_b_q > CW'(MAX_TERMS)), "fill count beyond store depth")

endmodule
